### sv/oldf_pkg.sv
// Shared types and constants for the ordered list difference filter.
`default_nettype none

package oldf_pkg;

    localparam int DATA_W             = 32;
    localparam int KEPT_DEPTH_DEF     = 64;
    localparam int REMOVAL_DEPTH_DEF  = 64;

    // Input item mode codes
    localparam logic [1:0] MODE_KEPT   = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_RUN    = 2'd2;

    // Kept value travelling down the compare chain
    typedef struct packed {
        logic                     vld;  // carries a kept value
        logic                     fin;  // final token of the run
        logic                     hit;  // matched some removal value
        logic signed [DATA_W-1:0] val;
    } t_tok;

    // Per-cycle control broadcast to every cell
    typedef struct packed {
        logic adv;  // shift the chain
        logic wr;   // removal load this cycle
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_run_state;

endpackage

`default_nettype wire

### sv/ordered_list_difference_filter.sv
// Top level: kept-list memory, compare chain sequencer and result staging.
//
// Input channel (i_in_valid / o_in_stall, fields i_mode, i_value): mode 0
// appends a kept value, mode 1 appends a removal value, mode 2 starts a run,
// mode 3 is taken and ignored. Loads are taken while idle; a load into a
// full list is dropped and flagged as overflow on the next run's results.
// Output channel (o_out_valid / i_out_stall): one item per surviving kept
// value in load order, the final one with o_last; a run with no survivor
// gives one item with o_empty_res and o_last set.
// A run reads the kept memory one entry a cycle, unless the chain is held,
// into a chain of REMOVAL_DEPTH compare cells, one removal value per cell.
// Each survivor waits in a pending register until the next survivor or the
// final entry shows whether it is last. Each entry passes the read-data and
// feed registers and then one register per cell, so the chain length sets
// the latency and the single memory read port the one-value-per-cycle rate.
// o_in_stall stays high from the run item until the run's last result is in
// the output register. A receiver stall holds the whole chain once a result
// waits for the output register. Reset (synchronous, active low) empties
// both lists, clears the overflow flag and drops any run in progress.
`default_nettype none

module ordered_list_difference_filter import oldf_pkg::*; #(
    parameter int KEPT_DEPTH    = KEPT_DEPTH_DEF,
    parameter int REMOVAL_DEPTH = REMOVAL_DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [1:0]               i_mode,
    input  wire logic signed [DATA_W-1:0] i_value,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic signed [DATA_W-1:0]      o_value_res,
    output logic                          o_last,
    output logic                          o_empty_res,
    output logic                          o_overflow
);

    localparam int KCW = $clog2(KEPT_DEPTH + 1);
    localparam int KAW = (KEPT_DEPTH > 1) ? $clog2(KEPT_DEPTH) : 1;
    localparam int RCW = $clog2(REMOVAL_DEPTH + 1);

    // Control state
    t_run_state      r_state, n_state;
    logic [KCW-1:0]  r_kept_cnt;
    logic [RCW-1:0]  r_rem_cnt;
    logic            r_dropped;
    logic            r_run_ovf;
    logic [KAW-1:0]  r_issue_idx;
    logic            r_feed_vld;
    logic            r_feed_fin;

    // Kept memory and read data
    logic signed [DATA_W-1:0] r_kept [KEPT_DEPTH];
    logic signed [DATA_W-1:0] r_rd_data;

    // Pending survivor and output register
    logic                     r_p_vld;
    logic                     r_p_fin;
    logic signed [DATA_W-1:0] r_p_val;
    logic                     r_o_vld;
    logic signed [DATA_W-1:0] r_o_val;
    logic                     r_o_last;
    logic                     r_o_empty;
    logic                     r_o_ovf;

    logic      in_acc;
    logic      kept_wr;
    logic      rem_wr;
    logic      run_start;
    logic      issue;
    logic      issue_end;
    logic      adv;
    logic      o_free;
    logic      tail_busy;
    logic      survivor;
    logic      need_out;
    logic      tail_take;
    logic      run_done;
    t_cell_ctl cell_ctl;
    t_tok      chain [REMOVAL_DEPTH+1];

    assign in_acc = i_in_valid && !o_in_stall;

    // Decode the accepted item
    always_comb begin
        kept_wr   = 1'b0;
        rem_wr    = 1'b0;
        run_start = 1'b0;
        if (in_acc) begin
            unique case (i_mode)
                MODE_KEPT:   kept_wr   = r_kept_cnt < KCW'(KEPT_DEPTH);
                MODE_REMOVE: rem_wr    = r_rem_cnt < RCW'(REMOVAL_DEPTH);
                MODE_RUN:    run_start = 1'b1;
                default:     run_start = 1'b0;
            endcase
        end
    end

    // Tail of the chain and result staging decisions
    assign tail_busy = chain[REMOVAL_DEPTH].vld || chain[REMOVAL_DEPTH].fin;
    assign survivor  = chain[REMOVAL_DEPTH].vld && !chain[REMOVAL_DEPTH].hit;
    assign need_out  = (survivor && r_p_vld) || (chain[REMOVAL_DEPTH].fin && !survivor);
    assign o_free    = !r_o_vld || !i_out_stall;
    assign adv       = !r_p_fin && (!tail_busy || !need_out || o_free);
    assign tail_take = adv && tail_busy;
    assign run_done  = (r_p_fin && o_free)
                     || (tail_take && chain[REMOVAL_DEPTH].fin && !survivor);
    assign issue_end = (r_kept_cnt == '0)
                     || ((KCW'(r_issue_idx) + KCW'(1)) == r_kept_cnt);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (run_start) n_state = ST_RUN;
            ST_RUN:   if (adv && issue_end) n_state = ST_DRAIN;
            ST_DRAIN: if (run_done) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_in_stall = 1'b1;
        issue      = 1'b0;
        unique case (r_state)
            ST_IDLE:  o_in_stall = 1'b0;
            ST_RUN:   issue      = adv;
            ST_DRAIN: issue      = 1'b0;
            default:  o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // List fill counts and overflow tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept_cnt <= '0;
            r_rem_cnt  <= '0;
            r_dropped  <= 1'b0;
            r_run_ovf  <= 1'b0;
        end else begin
            if (kept_wr) r_kept_cnt <= r_kept_cnt + KCW'(1);
            if (rem_wr)  r_rem_cnt  <= r_rem_cnt + RCW'(1);
            if (in_acc && (((i_mode == MODE_KEPT) && !kept_wr)
                        || ((i_mode == MODE_REMOVE) && !rem_wr))) begin
                r_dropped <= 1'b1;
            end
            if (run_start) begin
                r_run_ovf <= r_dropped;
                r_dropped <= 1'b0;
            end
            if (run_done) begin
                r_kept_cnt <= '0;
                r_rem_cnt  <= '0;
            end
        end
    end

    // Kept memory write
    always_ff @(posedge i_clk) begin
        if (kept_wr) begin
            r_kept[r_kept_cnt[KAW-1:0]] <= i_value;
        end
    end

    // Kept memory read, held while the chain stalls
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rd_data <= r_kept[r_issue_idx];
        end
    end

    // Issue kept entries into the chain head
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue_idx <= '0;
            r_feed_vld  <= 1'b0;
            r_feed_fin  <= 1'b0;
        end else begin
            if (run_start) begin
                r_issue_idx <= '0;
            end else if (issue) begin
                r_issue_idx <= r_issue_idx + KAW'(1);
            end
            if (adv) begin
                r_feed_vld <= issue && (r_kept_cnt != '0);
                r_feed_fin <= issue && issue_end;
            end
        end
    end

    assign chain[0]     = '{vld: r_feed_vld, fin: r_feed_fin, hit: 1'b0, val: r_rd_data};
    assign cell_ctl.adv = adv;
    assign cell_ctl.wr  = rem_wr;

    // Compare chain, one removal value per cell
    for (genvar g = 0; g < REMOVAL_DEPTH; g++) begin : g_cell
        oldf_cell #(
            .IDX   (g),
            .CNT_W (RCW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (cell_ctl),
            .i_cnt      (r_rem_cnt),
            .i_wr_value (i_value),
            .i_tok      (chain[g]),
            .o_tok      (chain[g+1])
        );
    end

    // Hold one survivor back until the next one shows whether it is last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_p_fin <= 1'b0;
        end else if (r_p_fin) begin
            if (o_free) begin
                r_p_vld <= 1'b0;
                r_p_fin <= 1'b0;
            end
        end else if (tail_take) begin
            if (survivor) begin
                r_p_vld <= 1'b1;
                r_p_fin <= chain[REMOVAL_DEPTH].fin;
            end else if (chain[REMOVAL_DEPTH].fin) begin
                r_p_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tail_take && survivor) begin
            r_p_val <= chain[REMOVAL_DEPTH].val;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if ((r_p_fin && o_free) || (tail_take && need_out)) begin
            r_o_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p_fin && o_free) begin
            r_o_val   <= r_p_val;
            r_o_last  <= 1'b1;
            r_o_empty <= 1'b0;
            r_o_ovf   <= r_run_ovf;
        end else if (tail_take && need_out) begin
            r_o_ovf <= r_run_ovf;
            if (survivor) begin
                r_o_val   <= r_p_val;
                r_o_last  <= 1'b0;
                r_o_empty <= 1'b0;
            end else if (r_p_vld) begin
                r_o_val   <= r_p_val;
                r_o_last  <= 1'b1;
                r_o_empty <= 1'b0;
            end else begin
                r_o_val   <= '0;
                r_o_last  <= 1'b1;
                r_o_empty <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_o_vld;
    assign o_value_res = r_o_val;
    assign o_last      = r_o_last;
    assign o_empty_res = r_o_empty;
    assign o_overflow  = r_o_ovf;

`ifndef SYNTHESIS
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_empty_res |-> o_last)
        else $error("empty result without last");

    a_fin_needs_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_fin |-> r_p_vld)
        else $error("final mark on empty pending slot");

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!tail_busy && !r_p_vld && !r_feed_vld && !r_feed_fin))
        else $error("chain not drained while idle");

    a_kept_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept_cnt <= KCW'(KEPT_DEPTH))
        else $error("kept count beyond depth");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        run_done |=> (r_kept_cnt == '0) && (r_rem_cnt == '0) && (r_state == ST_IDLE))
        else $error("run end did not clear lists");
`endif

endmodule

`default_nettype wire

### sv/oldf_cell.sv
// One compare cell: holds one removal value and tests each passing kept value.
`default_nettype none

module oldf_cell import oldf_pkg::*; #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cell_ctl                i_ctl,
    input  wire logic [CNT_W-1:0]         i_cnt,
    input  wire logic signed [DATA_W-1:0] i_wr_value,
    input  wire t_tok                     i_tok,
    output t_tok                          o_tok
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic signed [DATA_W-1:0] r_rem;
    t_tok                     r_tok;
    t_tok                     n_tok;
    logic                     live;

    // Entry is live once the removal list has grown past this slot
    assign live = MY_IDX < i_cnt;

    // Capture the removal value when the list fill reaches this slot
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && (i_cnt == MY_IDX)) begin
            r_rem <= i_wr_value;
        end
    end

    // Accumulate the match flag
    always_comb begin
        n_tok     = i_tok;
        n_tok.hit = i_tok.hit | (live && i_tok.vld && (i_tok.val == r_rem));
    end

    // Advance the token to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
            r_tok.fin <= 1'b0;
        end else if (i_ctl.adv) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

### tb/sv/tb_ordered_list_difference_filter.sv
`timescale 1ns / 100ps
// Self-checking testbench for the ordered list difference filter.
module tb_ordered_list_difference_filter;
    import oldf_pkg::*;

    localparam logic [1:0] MODE_IGNORED = 2'd3;
    localparam int ITEM_TARGET  = 170;
    localparam int FILL_AFTER   = 40;
    localparam int QUIET_LIMIT  = 5000;
    localparam int LONG_HOLD    = 300;
    localparam int TAIL_CYCLES  = KEPT_DEPTH_DEF + REMOVAL_DEPTH_DEF + 16;
    localparam int MAX_REPORTS  = 10;
    localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] INT_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    typedef struct packed {
        logic signed [DATA_W-1:0] value_res;
        logic                     last;
        logic                     empty_res;
        logic                     overflow;
    } t_result;

    typedef struct packed {
        logic [1:0]               mode;
        logic signed [DATA_W-1:0] value;
        logic                     typed;
        t_result                  want;
    } t_stim_row;

    localparam t_result EMPTY_RUN = '{value_res: '0, last: 1'b1, empty_res: 1'b1,
                                      overflow: 1'b0};
    localparam t_result LONE_MIN  = '{value_res: INT_MIN, last: 1'b1, empty_res: 1'b0,
                                      overflow: 1'b0};

    logic                     i_clk;
    logic                     i_rst_n     = 1'b0;
    logic                     i_in_valid  = 1'b0;
    logic [1:0]               i_mode      = MODE_KEPT;
    logic signed [DATA_W-1:0] i_value     = '0;
    logic                     i_out_stall = 1'b0;
    logic                     o_in_stall;
    logic                     o_out_valid;
    logic signed [DATA_W-1:0] o_value_res;
    logic                     o_last;
    logic                     o_empty_res;
    logic                     o_overflow;

    // Predicted list contents and the survivors still due
    logic signed [DATA_W-1:0] kept_list[$];
    logic signed [DATA_W-1:0] removal_list[$];
    logic                     dropped_seen = 1'b0;
    t_result                  survivors_due[$];
    logic signed [DATA_W-1:0] value_pool[8];

    int  n_items         = 0;
    int  n_ignored       = 0;
    int  n_runs          = 0;
    int  n_empty_runs    = 0;
    int  n_overflow_runs = 0;
    int  n_results       = 0;
    int  n_errors        = 0;
    bit  rx_hold_req     = 1'b0;

    ordered_list_difference_filter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_value_res (o_value_res),
        .o_last      (o_last),
        .o_empty_res (o_empty_res),
        .o_overflow  (o_overflow)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hold reset low from the start, then release for good
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Apply one accepted item to the predicted lists
    function automatic void predict_difference(input logic [1:0] md,
                                               input logic signed [DATA_W-1:0] val);
        t_result r;
        bit      hit;
        bit      any_left;
        case (md)
            MODE_KEPT: begin
                if (kept_list.size() < KEPT_DEPTH_DEF) kept_list.push_back(val);
                else dropped_seen = 1'b1;
            end
            MODE_REMOVE: begin
                if (removal_list.size() < REMOVAL_DEPTH_DEF) removal_list.push_back(val);
                else dropped_seen = 1'b1;
            end
            MODE_RUN: begin
                any_left = 1'b0;
                foreach (kept_list[i]) begin
                    hit = 1'b0;
                    foreach (removal_list[j]) begin
                        if (removal_list[j] == kept_list[i]) hit = 1'b1;
                    end
                    if (!hit) begin
                        r = '{value_res: kept_list[i], last: 1'b0, empty_res: 1'b0,
                              overflow: dropped_seen};
                        survivors_due.push_back(r);
                        any_left = 1'b1;
                    end
                end
                if (any_left) begin
                    survivors_due[survivors_due.size()-1].last = 1'b1;
                end else begin
                    r = EMPTY_RUN;
                    r.overflow = dropped_seen;
                    survivors_due.push_back(r);
                    n_empty_runs++;
                end
                n_runs++;
                if (dropped_seen) n_overflow_runs++;
                kept_list.delete();
                removal_list.delete();
                dropped_seen = 1'b0;
            end
            default: ;
        endcase
    endfunction

    function automatic t_stim_row stim_row(input logic [1:0] md,
                                           input logic signed [DATA_W-1:0] val,
                                           input logic typed = 1'b0,
                                           input t_result want = '0);
        stim_row = '{mode: md, value: val, typed: typed, want: want};
    endfunction

    // Mostly pool values so that kept and removal values collide
    function automatic logic signed [DATA_W-1:0] pick_value();
        if ($urandom_range(9) < 6) return value_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    task automatic note_error(input string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Offer one item, wait for it to be taken, then predict its results
    task automatic send_item(input logic [1:0] md, input logic signed [DATA_W-1:0] val,
                             input logic typed = 1'b0, input t_result want = '0);
        int due_before;
        while (!(n_items >= 100 && n_items < 150) && $urandom_range(99) < 16) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= md;
        i_value    <= val;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        due_before = survivors_due.size();
        predict_difference(md, val);
        // Rows with a hand-written result replace the predicted one
        if (typed) begin
            while (survivors_due.size() > due_before) void'(survivors_due.pop_back());
            survivors_due.push_back(want);
        end
        if (md == MODE_IGNORED) n_ignored++;
        else n_items++;
    endtask

    // Receiver: check every taken result, stall at random and once for long
    initial begin : receiver
        t_result got;
        t_result want;
        int      hold_left;
        int      rx_cycle;
        hold_left = 0;
        rx_cycle  = 0;
        forever begin
            @(posedge i_clk);
            rx_cycle++;
            if (o_out_valid && !i_out_stall) begin
                got = '{value_res: o_value_res, last: o_last, empty_res: o_empty_res,
                        overflow: o_overflow};
                n_results++;
                if (survivors_due.size() == 0) begin
                    note_error($sformatf("unexpected result value=%0d last=%0b empty=%0b ovf=%0b",
                                         got.value_res, got.last, got.empty_res, got.overflow));
                end else begin
                    want = survivors_due.pop_front();
                    if (got.value_res !== want.value_res || got.last !== want.last ||
                        got.empty_res !== want.empty_res || got.overflow !== want.overflow) begin
                        note_error($sformatf({"expected value=%0d last=%0b empty=%0b ovf=%0b, ",
                                              "got value=%0d last=%0b empty=%0b ovf=%0b"},
                                             want.value_res, want.last, want.empty_res,
                                             want.overflow, got.value_res, got.last,
                                             got.empty_res, got.overflow));
                    end
                end
            end
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (rx_cycle >= 300 && rx_cycle < 800) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < 16);
            end
        end
    end

    // Watchdog: give up when nothing moves on either side for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet = 0;
            else quiet++;
        end
        $display("watchdog: nothing moved for %0d cycles, %0d results still due",
                 QUIET_LIMIT, survivors_due.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        t_stim_row rows[$];
        int        nk;
        int        nr;
        int        seq;
        bit        to_kept;
        bit        fill_done;
        bit        paused;

        value_pool[0] = INT_MIN;
        value_pool[1] = INT_MAX;
        value_pool[2] = '0;
        value_pool[3] = -1;
        for (int p = 4; p < 8; p++) value_pool[p] = $urandom;

        // Directed rows: extremes, duplicates, reserved mode, empty runs
        rows = '{
            stim_row(MODE_RUN,     32'sd0, 1'b1, EMPTY_RUN),
            stim_row(MODE_KEPT,    INT_MIN),
            stim_row(MODE_RUN,     32'sd0, 1'b1, LONE_MIN),
            stim_row(MODE_KEPT,    INT_MAX),
            stim_row(MODE_KEPT,    INT_MIN),
            stim_row(MODE_KEPT,    32'sd0),
            stim_row(MODE_KEPT,    -32'sd1),
            stim_row(MODE_KEPT,    INT_MAX),
            stim_row(MODE_REMOVE,  32'sd0),
            stim_row(MODE_IGNORED, 32'sh5a5a_5a5a),
            stim_row(MODE_REMOVE,  INT_MIN),
            stim_row(MODE_RUN,     -32'sd1),
            stim_row(MODE_KEPT,    32'sd5),
            stim_row(MODE_REMOVE,  32'sd5),
            stim_row(MODE_RUN,     INT_MAX, 1'b1, EMPTY_RUN),
            stim_row(MODE_REMOVE,  32'sd1),
            stim_row(MODE_IGNORED, -32'sd1),
            stim_row(MODE_RUN,     32'sd0, 1'b1, EMPTY_RUN),
            stim_row(MODE_KEPT,    32'sd3),
            stim_row(MODE_KEPT,    32'sd3),
            stim_row(MODE_REMOVE,  32'sd3),
            stim_row(MODE_REMOVE,  32'sd3),
            stim_row(MODE_RUN,     32'sd0, 1'b1, EMPTY_RUN)
        };

        @(posedge i_rst_n);
        @(posedge i_clk);
        foreach (rows[k]) send_item(rows[k].mode, rows[k].value, rows[k].typed, rows[k].want);

        // Random sequences: loads with colliding values, then a run
        seq       = 0;
        fill_done = 1'b0;
        paused    = 1'b0;
        while (n_items < ITEM_TARGET) begin
            seq++;
            if (!paused && seq == 3) begin
                // drain everything before the next sequence
                paused = 1'b1;
                i_in_valid <= 1'b0;
                while (survivors_due.size() != 0) @(posedge i_clk);
            end
            if (!fill_done && n_items >= FILL_AFTER) begin
                // overfill both lists
                nk = KEPT_DEPTH_DEF + $urandom_range(1, 3);
                nr = REMOVAL_DEPTH_DEF + $urandom_range(1, 2);
            end else if ($urandom_range(9) == 0) begin
                // noise: any mode, reserved code included
                repeat ($urandom_range(1, 3)) send_item(2'($urandom_range(3)), pick_value());
                continue;
            end else begin
                nk = $urandom_range(0, 8);
                nr = $urandom_range(0, 6);
            end
            while (nk + nr > 0) begin
                to_kept = (nr == 0) || (nk != 0 && $urandom_range(1) == 1);
                if ($urandom_range(19) == 0) send_item(MODE_IGNORED, $urandom);
                if (to_kept) begin
                    send_item(MODE_KEPT, pick_value());
                    nk--;
                end else begin
                    send_item(MODE_REMOVE, pick_value());
                    nr--;
                end
            end
            // the long receiver hold lands on the full-list run
            if (!fill_done && n_items >= FILL_AFTER) begin
                fill_done   = 1'b1;
                rx_hold_req = 1'b1;
            end
            send_item(MODE_RUN, $urandom);
        end
        i_in_valid <= 1'b0;

        // Wait out the results, then watch for strays
        while (survivors_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d loads and runs plus %0d reserved-mode items", n_items, n_ignored);
        $display("%0d runs (%0d empty, %0d with overflow), %0d results checked, %0d errors",
                 n_runs, n_empty_runs, n_overflow_runs, n_results, n_errors);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
